/* hw/rtl/toeq_pkg.sv */
`default_nettype none

package toeq_pkg;

    localparam int unsigned IN_TIME_W = 32;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned VEH_W     = 10;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned COUNT_W   = 7;
    // kind, vehicle and urgency bits stored below the time stamp in a slot
    localparam int unsigned TAG_W     = KIND_W + VEH_W + 1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_WAIT,
        S_INS_SCAN,
        S_INS_PUT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic                 operation;
        logic [IN_TIME_W-1:0] event_time;
        logic [KIND_W-1:0]    event_kind;
        logic [VEH_W-1:0]     vehicle_id;
        logic                 urgency;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [IN_TIME_W-1:0] out_time;
        logic [KIND_W-1:0]    out_kind;
        logic [VEH_W-1:0]     out_vehicle;
        logic                 out_urgency;
        logic [COUNT_W-1:0]   occupancy;
        logic [COUNT_W-1:0]   peak_occupancy;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/toeq_mem.sv */
`default_nettype none

module toeq_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 45
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/toeq_ctrl.sv */
`default_nettype none

module toeq_ctrl
    import toeq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned TIME_WIDTH  = 32,
    localparam int unsigned AW = $clog2(QUEUE_DEPTH),
    localparam int unsigned SW = TIME_WIDTH + TAG_W
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire t_item         i_item,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output t_result            o_res,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [SW-1:0]      o_wr_data,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    input  wire logic [SW-1:0] i_rd_data
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        r = (a == AW'(QUEUE_DEPTH - 1)) ? '0 : a + AW'(1);
        return r;
    endfunction

    function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        r = (a == '0) ? AW'(QUEUE_DEPTH - 1) : a - AW'(1);
        return r;
    endfunction

    t_state                r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_peak, n_peak;
    logic [CW-1:0]         r_pos, n_pos;
    logic [AW-1:0]         r_rd_addr, n_rd_addr;
    logic [AW-1:0]         r_wr_addr, n_wr_addr;
    logic [TIME_WIDTH-1:0] r_time, n_time;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [VEH_W-1:0]      r_veh, n_veh;
    logic                  r_urg, n_urg;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic                  r_has_data, n_has_data;

    logic [AW:0]           tail_sum;
    logic [AW-1:0]         tail_next;
    logic [CW-1:0]         cnt_inc;
    logic [CW-1:0]         peak_inc;
    logic [TIME_WIDTH-1:0] rd_time;
    logic [SW-1:0]         own_slot;
    logic [SW-1:0]         in_slot;

    // physical address of the first free slot after the stored run
    assign tail_sum  = (AW+1)'(r_head) + (AW+1)'(r_count);
    assign tail_next = (tail_sum >= (AW+1)'(QUEUE_DEPTH))
                       ? AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
    assign cnt_inc   = r_count + CW'(1);
    assign peak_inc  = (cnt_inc > r_peak) ? cnt_inc : r_peak;
    assign rd_time   = i_rd_data[SW-1:TAG_W];
    assign own_slot  = {r_time, r_kind, r_veh, r_urg};
    assign in_slot   = {TIME_WIDTH'(i_item.event_time), i_item.event_kind,
                        i_item.vehicle_id, i_item.urgency};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_peak  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_peak  <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_rd_addr  <= n_rd_addr;
        r_wr_addr  <= n_wr_addr;
        r_time     <= n_time;
        r_kind     <= n_kind;
        r_veh      <= n_veh;
        r_urg      <= n_urg;
        r_status   <= n_status;
        r_has_data <= n_has_data;
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_peak     = r_peak;
        n_pos      = r_pos;
        n_rd_addr  = r_rd_addr;
        n_wr_addr  = r_wr_addr;
        n_time     = r_time;
        n_kind     = r_kind;
        n_veh      = r_veh;
        n_urg      = r_urg;
        n_status   = r_status;
        n_has_data = r_has_data;
        o_in_ready = 1'b0;
        o_res_valid = 1'b0;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_wr_addr;
        o_wr_data  = own_slot;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_rd_addr;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_time     = TIME_WIDTH'(i_item.event_time);
                    n_kind     = i_item.event_kind;
                    n_veh      = i_item.vehicle_id;
                    n_urg      = i_item.urgency;
                    n_has_data = 1'b0;
                    n_status   = ST_OK;
                    n_state    = S_RESULT;
                    if (i_item.operation == OP_POP) begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = r_head;
                            n_state   = S_POP_WAIT;
                        end
                    end else if (r_count == CW'(QUEUE_DEPTH)) begin
                        n_status = ST_FULL;
                    end else if (r_count == '0) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_head;
                        o_wr_data = in_slot;
                        n_count   = cnt_inc;
                        n_peak    = peak_inc;
                    end else begin
                        // walk down from the last stored event
                        o_rd_en   = 1'b1;
                        o_rd_addr = addr_dec(tail_next);
                        n_rd_addr = addr_dec(tail_next);
                        n_wr_addr = tail_next;
                        n_pos     = r_count;
                        n_state   = S_INS_SCAN;
                    end
                end
            end
            S_POP_WAIT: begin
                n_time     = i_rd_data[SW-1:TAG_W];
                n_kind     = i_rd_data[TAG_W-1:VEH_W+1];
                n_veh      = i_rd_data[VEH_W:1];
                n_urg      = i_rd_data[0];
                n_has_data = 1'b1;
                n_head     = addr_inc(r_head);
                n_count    = r_count - CW'(1);
                n_state    = S_RESULT;
            end
            S_INS_SCAN: begin
                o_wr_en = 1'b1;
                if (rd_time > r_time) begin
                    // move the later event up one slot
                    o_wr_data = i_rd_data;
                    n_wr_addr = r_rd_addr;
                    n_rd_addr = addr_dec(r_rd_addr);
                    n_pos     = r_pos - CW'(1);
                    if (r_pos == CW'(1)) begin
                        n_state = S_INS_PUT;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = addr_dec(r_rd_addr);
                    end
                end else begin
                    n_count = cnt_inc;
                    n_peak  = peak_inc;
                    n_state = S_RESULT;
                end
            end
            S_INS_PUT: begin
                o_wr_en = 1'b1;
                n_count = cnt_inc;
                n_peak  = peak_inc;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.status         = r_status;
        o_res.out_time       = r_has_data ? IN_TIME_W'(r_time) : '0;
        o_res.out_kind       = r_has_data ? r_kind : '0;
        o_res.out_vehicle    = r_has_data ? r_veh : '0;
        o_res.out_urgency    = r_has_data & r_urg;
        o_res.occupancy      = COUNT_W'(r_count);
        o_res.peak_occupancy = COUNT_W'(r_peak);
    end

endmodule

`default_nettype wire

/* hw/rtl/time_ordered_event_queue_top.sv */
`default_nettype none
// time-ordered event queue: holds up to QUEUE_DEPTH events sorted by time stamp
// slave channel: one beat is one operation, tuser picks insert (0) or pop (1),
// tdata carries the event; equal time stamps leave in arrival order
// master channel: one beat per operation with status in tuser and the popped
// event plus occupancy and peak occupancy in tdata
// the events sit in a circular buffer in a one-port-read, one-port-write ram;
// a pop reads the head slot
// an insert walks down from the tail moving later events up one slot per
// cycle, one move for each stored event later than the new one, then writes
// the new event; full, pop-on-empty and insert-into-empty cases need no walk
// one operation is in work at a time; a new beat is taken once the previous
// result sits in the output register, even while that result waits
// if the receiver stalls, the finished result waits inside and no further beat
// is taken until the output register frees up
// reset (synchronous, active low) empties the queue and clears the peak; the
// ram needs no clearing since only slots written by an insert are read
module time_ordered_event_queue_top
    import toeq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned TIME_WIDTH  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // event_time[31:0], event_kind[33:32], vehicle_id[43:34], urgency[44], zero pad
    input  wire logic [47:0] i_s_axis_tdata,
    // operation[0]
    input  wire logic [0:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // out_time[31:0], out_kind[33:32], out_vehicle[43:34], out_urgency[44],
    // occupancy[51:45], peak_occupancy[58:52], zero pad
    output logic [63:0]      o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]       o_m_axis_tuser
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned SW = TIME_WIDTH + TAG_W;

    t_item          in_item;
    t_result        res;
    logic           res_valid;
    logic           res_ready;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [SW-1:0]  wr_data;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [SW-1:0]  rd_data;

    logic           r_out_valid;
    t_result        r_out;

    assign in_item.operation  = i_s_axis_tuser[0];
    assign in_item.event_time = i_s_axis_tdata[31:0];
    assign in_item.event_kind = i_s_axis_tdata[33:32];
    assign in_item.vehicle_id = i_s_axis_tdata[43:34];
    assign in_item.urgency    = i_s_axis_tdata[44];

    toeq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    toeq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (SW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register: free when empty or its beat leaves this cycle
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {5'b0, r_out.peak_occupancy, r_out.occupancy,
                              r_out.out_urgency, r_out.out_vehicle, r_out.out_kind,
                              r_out.out_time};

endmodule

`default_nettype wire

/* tb/tb_time_ordered_event_queue_top.sv */
`timescale 1ns / 100ps

module tb_time_ordered_event_queue_top;
    import toeq_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int END_CYCLES  = 100;

    typedef struct packed {
        logic [IN_TIME_W-1:0] stamp;
        logic [KIND_W-1:0]    kind;
        logic [VEH_W-1:0]     vehicle;
        logic                 urgent;
    } t_stored_event;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [47:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [63:0] m_tdata;
    wire  [1:0]  m_tuser;

    // time-sorted copy of the queue contents and the results still owed
    t_stored_event model_events[$];
    t_result       awaited_results[$];
    int            model_peak = 0;

    int fail_count   = 0;
    int quiet_cycles = 0;
    int rx_hold_left = 0;
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    int n_inserts    = 0;
    int n_full       = 0;
    int n_pops       = 0;
    int n_empty      = 0;
    int n_checked    = 0;

    time_ordered_event_queue_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_result apply_event_op(input logic op, input logic [31:0] stamp,
                                               input logic [1:0] kind, input logic [9:0] veh,
                                               input logic urg);
        t_result       r;
        t_stored_event ev;
        int            pos;
        r = '0;
        if (op == OP_INSERT) begin
            n_inserts++;
            if (model_events.size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
                n_full++;
            end else begin
                ev = {stamp, kind, veh, urg};
                // goes behind every event with an equal or earlier stamp
                pos = model_events.size();
                while (pos > 0 && model_events[pos-1].stamp > stamp)
                    pos--;
                model_events.insert(pos, ev);
                if (model_events.size() > model_peak)
                    model_peak = model_events.size();
                r.status = ST_OK;
            end
        end else begin
            n_pops++;
            if (model_events.size() == 0) begin
                r.status = ST_EMPTY;
                n_empty++;
            end else begin
                ev = model_events.pop_front();
                r.status      = ST_OK;
                r.out_time    = ev.stamp;
                r.out_kind    = ev.kind;
                r.out_vehicle = ev.vehicle;
                r.out_urgency = ev.urgent;
            end
        end
        r.occupancy      = COUNT_W'(model_events.size());
        r.peak_occupancy = COUNT_W'(model_peak);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [31:0] pick_time(input logic [31:0] span);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return $urandom;
            default: return $urandom_range(span);
        endcase
    endfunction

    // result side: compare each accepted beat with the oldest owed result
    always @(posedge i_clk) begin : check_beat
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.status         = m_tuser;
            got.out_time       = m_tdata[31:0];
            got.out_kind       = m_tdata[33:32];
            got.out_vehicle    = m_tdata[43:34];
            got.out_urgency    = m_tdata[44];
            got.occupancy      = m_tdata[51:45];
            got.peak_occupancy = m_tdata[58:52];
            if (awaited_results.size() == 0) begin
                $error("result beat with no operation outstanding");
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                n_checked++;
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("out_time", want.out_time, got.out_time);
                check_field("out_kind", 32'(want.out_kind), 32'(got.out_kind));
                check_field("out_vehicle", 32'(want.out_vehicle), 32'(got.out_vehicle));
                check_field("out_urgency", 32'(want.out_urgency), 32'(got.out_urgency));
                check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
                check_field("peak_occupancy", 32'(want.peak_occupancy),
                            32'(got.peak_occupancy));
            end
        end
    end

    // receiver: random stalls, plus a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            m_tready <= !(rx_idle_on && $urandom_range(99) < 15);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("no beat moved for %0d cycles, %0d results owed",
                         quiet_cycles, awaited_results.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_op(input logic op, input logic [31:0] stamp, input logic [1:0] kind,
                           input logic [9:0] veh, input logic urg);
        int gap;
        gap = (tx_idle_on && $urandom_range(99) < 15) ? $urandom_range(1, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, urg, veh, kind, stamp};
        do
            @(posedge i_clk);
        while (!s_tready);
        awaited_results.push_back(apply_event_op(op, stamp, kind, veh, urg));
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_all_results();
        stop_sending();
        while (awaited_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random_ops(input int count, input int insert_pct,
                                  input logic [31:0] span);
        logic op;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP;
            send_op(op, pick_time(span), 2'($urandom_range(3)),
                    10'($urandom_range(1023)), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_directed();
        send_op(OP_POP, '0, 2'd0, 10'd0, 1'b0);
        send_op(OP_INSERT, 32'h0000_0100, 2'd0, 10'd0, 1'b0);
        send_op(OP_INSERT, 32'hFFFF_FFFF, 2'd3, 10'd1023, 1'b1);
        send_op(OP_INSERT, 32'h0000_0000, 2'd1, 10'd1, 1'b1);
        // equal stamps must leave in arrival order
        send_op(OP_INSERT, 32'h0000_0100, 2'd2, 10'd2, 1'b0);
        send_op(OP_INSERT, 32'h0000_0100, 2'd1, 10'd3, 1'b1);
        send_op(OP_INSERT, 32'h0000_0080, 2'd2, 10'd512, 1'b0);
        repeat (6) send_op(OP_POP, '1, 2'd3, 10'd1023, 1'b1);
        send_op(OP_POP, '0, 2'd0, 10'd0, 1'b0);
        send_op(OP_INSERT, 32'hAAAA_AAAA, 2'd2, 10'h155, 1'b0);
        send_op(OP_INSERT, 32'h5555_5555, 2'd1, 10'h2AA, 1'b1);
        send_op(OP_INSERT, 32'h5555_5555, 2'd3, 10'h3FF, 1'b0);
        repeat (3) send_op(OP_POP, '0, 2'd0, 10'd0, 1'b0);
        send_op(OP_POP, '0, 2'd0, 10'd0, 1'b0);
    endtask

    task automatic test_fill_past_full();
        run_random_ops(QUEUE_DEPTH - model_events.size(), 100, 32'd1000);
        send_op(OP_INSERT, '0, 2'd3, 10'd1023, 1'b1);
        send_op(OP_INSERT, '1, 2'd0, 10'd0, 1'b0);
        run_random_ops(QUEUE_DEPTH + 1, 0, 32'd0);
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random_ops(200, 55, 32'd63);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        // receiver holds off while the sender keeps offering beats
        rx_hold_left = 400;
        run_random_ops(40, 70, 32'd255);
    endtask

    task automatic test_pause_until_drained();
        run_random_ops(30, 60, 32'd4095);
        wait_all_results();
        run_random_ops(30, 40, 32'd4095);
    endtask

    task automatic test_random_mix();
        for (int round = 0; round < 3; round++) begin
            run_random_ops(100, 80, (round == 0) ? 32'd15 : 32'hFFFF);
            run_random_ops(100, 25, 32'd15);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_past_full();
        test_back_to_back();
        test_backpressure();
        test_pause_until_drained();
        test_random_mix();

        wait_all_results();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("checked %0d results: %0d inserts (%0d refused full), %0d pops (%0d empty)",
                 n_checked, n_inserts, n_full, n_pops, n_empty);
        $display("peak occupancy reached %0d of %0d slots", model_peak, QUEUE_DEPTH);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
